/* src/iisq_pkg.sv */
package iisq_pkg;

   // stream payload widths
   localparam int PIXEL_W    = 8;
   localparam int PIX_SQ_W   = 2 * PIXEL_W;
   localparam int PIXEL_MAX  = 255;
   localparam int PIX_SQ_MAX = 65025;
   localparam int SUM_OUT_W  = 28;
   localparam int SQ_OUT_W   = 36;

   // saturation limits of the result fields
   localparam logic [63:0] SUM_FIELD_MAX = 64'h0000_0000_0FFF_FFFF;
   localparam logic [63:0] SQ_FIELD_MAX  = 64'h0000_000F_FFFF_FFFF;

   // register file
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
   localparam logic [CFG_W-1:0]     CFG_SIZE_RESET   = 11'd1024;

   // position of the word being accepted
   typedef struct packed {
      logic first_row;
      logic end_row;
      logic frame_last;
   } pos_flags_type;

endpackage

/* src/iisq_if.sv */
interface iisq_req_if;
   logic                         valid;
   logic                         ready;
   logic [iisq_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface iisq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iisq_pkg::SUM_OUT_W-1:0] integral_sum;
   logic [iisq_pkg::SQ_OUT_W-1:0]  integral_square_sum;
   logic                           frame_last;

   modport source (output valid, output integral_sum, output integral_square_sum,
                   output frame_last, input ready);
   modport sink   (input valid, input integral_sum, input integral_square_sum,
                   input frame_last, output ready);
endinterface

interface iisq_csr_if;
   logic                           valid;
   logic                           ready;
   logic [iisq_pkg::CSR_IDX_W-1:0] index;
   logic [iisq_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/iisq_position.sv */
module iisq_position #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [iisq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iisq_pkg::CFG_W-1:0]       csr_data,
   input  logic                             accept,
   output logic [$clog2(MAX_WIDTH)-1:0]     col,
   output iisq_pkg::pos_flags_type          flags
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int LW = (iisq_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                       iisq_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
   localparam int LH = (iisq_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                       iisq_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);

   logic [iisq_pkg::CFG_W-1:0] width_ff, width_in;
   logic [iisq_pkg::CFG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;

   logic [LW-1:0] w_cfg, w_lim, col_next;
   logic [LH-1:0] h_cfg, h_lim, row_next;
   logic          end_row, last_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            iisq_pkg::REG_FRAME_WIDTH:  width_in  = csr_data;
            iisq_pkg::REG_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // a size of zero acts as one, an oversize acts as the maximum
   always_comb begin
      w_cfg = LW'(width_ff);
      h_cfg = LH'(height_ff);
      priority if (w_cfg == '0)              w_lim = LW'(1);
      else if (w_cfg > LW'(MAX_WIDTH))       w_lim = LW'(MAX_WIDTH);
      else                                   w_lim = w_cfg;
      priority if (h_cfg == '0)              h_lim = LH'(1);
      else if (h_cfg > LH'(MAX_HEIGHT))      h_lim = LH'(MAX_HEIGHT);
      else                                   h_lim = h_cfg;
      col_next = LW'(col_ff) + LW'(1);
      row_next = LH'(row_ff) + LH'(1);
      end_row  = col_next >= w_lim;
      last_row = row_next >= h_lim;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_row) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= iisq_pkg::CFG_SIZE_RESET;
         height_ff <= iisq_pkg::CFG_SIZE_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col              = col_ff;
   assign flags.first_row  = (row_ff == '0);
   assign flags.end_row    = end_row;
   assign flags.frame_last = end_row && last_row;

endmodule

/* src/iisq_datapath.sv */
module iisq_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [iisq_pkg::PIXEL_W-1:0]     pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]     col,
   input  iisq_pkg::pos_flags_type          flags,
   output logic                             in_ready,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [iisq_pkg::SUM_OUT_W-1:0]   rsp_sum,
   output logic [iisq_pkg::SQ_OUT_W-1:0]    rsp_sq,
   output logic                             rsp_last
);

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int FILL_W   = $clog2(MAX_WIDTH + 1);
   localparam int RS_W     = $clog2(iisq_pkg::PIXEL_MAX * MAX_WIDTH + 1);
   localparam int RQ_W     = $clog2(iisq_pkg::PIX_SQ_MAX * MAX_WIDTH + 1);
   localparam int SUM_NEED = $clog2(64'd255 * MAX_WIDTH * MAX_HEIGHT + 64'd1);
   localparam int SQ_NEED  = $clog2(64'd65025 * MAX_WIDTH * MAX_HEIGHT + 64'd1);
   // stored sums are never narrower than the result fields
   localparam int SUM_W    = (SUM_NEED > iisq_pkg::SUM_OUT_W) ? SUM_NEED : iisq_pkg::SUM_OUT_W;
   localparam int SQ_W     = (SQ_NEED > iisq_pkg::SQ_OUT_W) ? SQ_NEED : iisq_pkg::SQ_OUT_W;
   localparam int LINE_W   = SUM_W + SQ_W;
   localparam int EW_S     = (SUM_W > iisq_pkg::SUM_OUT_W) ? SUM_W : iisq_pkg::SUM_OUT_W;
   localparam int EW_Q     = (SQ_W > iisq_pkg::SQ_OUT_W) ? SQ_W : iisq_pkg::SQ_OUT_W;

   // control
   logic              s1_v_ff, s1_v_in;
   logic              out_v_ff, out_v_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [RS_W-1:0]   row_sum_ff, row_sum_in;
   logic [RQ_W-1:0]   row_sq_ff, row_sq_in;
   logic              out_adv, s1_adv, fwd;

   // stage one payload
   logic [RS_W-1:0]   s1_rs_ff, s1_rs_in;
   logic [RQ_W-1:0]   s1_rq_ff, s1_rq_in;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_last_ff;
   logic              s1_zero_ff, s1_zero_in;
   logic [LINE_W-1:0] rd_ff;
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];

   logic [iisq_pkg::PIX_SQ_W-1:0] pix_sq;
   logic [SUM_W-1:0]  above_sum, s1_sum;
   logic [SQ_W-1:0]   above_sq, s1_sq;
   logic [SUM_W:0]    sum_wide;
   logic [SQ_W:0]     sq_wide;
   logic [EW_S-1:0]   sum_ext;
   logic [EW_Q-1:0]   sq_ext;

   // output register
   logic [iisq_pkg::SUM_OUT_W-1:0] out_sum_ff, out_sum_in;
   logic [iisq_pkg::SQ_OUT_W-1:0]  out_sq_ff, out_sq_in;
   logic                           out_last_ff;

   assign out_adv  = !out_v_ff || rsp_ready;
   assign s1_adv   = s1_v_ff && out_adv;
   assign in_ready = !s1_v_ff || out_adv;
   // the word leaving stage one writes the column that the new word reads
   assign fwd      = s1_adv && (s1_col_ff == col);

   // row running sums
   always_comb begin
      pix_sq     = pixel * pixel;
      s1_rs_in   = row_sum_ff + RS_W'(pixel);
      s1_rq_in   = row_sq_ff + RQ_W'(pix_sq);
      row_sum_in = row_sum_ff;
      row_sq_in  = row_sq_ff;
      if (accept) begin
         row_sum_in = flags.end_row ? '0 : s1_rs_in;
         row_sq_in  = flags.end_row ? '0 : s1_rq_in;
      end
      // columns at or past the fill count were never written and read as zero
      s1_zero_in = flags.first_row || (!fwd && (FILL_W'(col) >= fill_ff));
   end

   // integral values and saturation
   always_comb begin
      above_sum  = s1_zero_ff ? '0 : rd_ff[LINE_W-1 -: SUM_W];
      above_sq   = s1_zero_ff ? '0 : rd_ff[SQ_W-1:0];
      sum_wide   = {1'b0, above_sum} + (SUM_W+1)'(s1_rs_ff);
      sq_wide    = {1'b0, above_sq} + (SQ_W+1)'(s1_rq_ff);
      // a carry out pins the stored sum at all ones, at or above the field maximum
      s1_sum     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      s1_sq      = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
      sum_ext    = EW_S'(s1_sum);
      sq_ext     = EW_Q'(s1_sq);
      out_sum_in = (sum_ext > EW_S'(iisq_pkg::SUM_FIELD_MAX)) ?
                   iisq_pkg::SUM_OUT_W'(iisq_pkg::SUM_FIELD_MAX) :
                   sum_ext[iisq_pkg::SUM_OUT_W-1:0];
      out_sq_in  = (sq_ext > EW_Q'(iisq_pkg::SQ_FIELD_MAX)) ?
                   iisq_pkg::SQ_OUT_W'(iisq_pkg::SQ_FIELD_MAX) :
                   sq_ext[iisq_pkg::SQ_OUT_W-1:0];
   end

   always_comb begin
      s1_v_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
      out_v_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);
      fill_in  = fill_ff;
      if (s1_adv && (FILL_W'(s1_col_ff) == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         fill_ff    <= '0;
         row_sum_ff <= '0;
         row_sq_ff  <= '0;
      end else begin
         s1_v_ff    <= s1_v_in;
         out_v_ff   <= out_v_in;
         fill_ff    <= fill_in;
         row_sum_ff <= row_sum_in;
         row_sq_ff  <= row_sq_in;
      end
   end

   // line store of previous row integral values
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {s1_sum, s1_sq};
      end
      if (accept) begin
         rd_ff <= fwd ? {s1_sum, s1_sq} : line_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rs_ff   <= s1_rs_in;
         s1_rq_ff   <= s1_rq_in;
         s1_col_ff  <= col;
         s1_last_ff <= flags.frame_last;
         s1_zero_ff <= s1_zero_in;
      end
      if (s1_adv) begin
         out_sum_ff  <= out_sum_in;
         out_sq_ff   <= out_sq_in;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_sum   = out_sum_ff;
   assign rsp_sq    = out_sq_ff;
   assign rsp_last  = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_WIDTH))
      else $error("fill count beyond line store depth");

   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_v_ff)
      else $error("word left stage one but output register is empty");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !out_adv) |=> (s1_v_ff && $stable(s1_col_ff) && $stable(rd_ff)))
      else $error("stage one changed while stalled");

   a_fwd_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (fwd && accept) |=> (s1_v_ff && !s1_zero_ff || $past(flags.first_row)))
      else $error("forwarded column read as zero");

endmodule

/* src/integral_and_squared_integral_image_unit.sv */
// channel   dir  handshake     payload
// req_chan  in   valid/ready   pixel[7:0]
// rsp_chan  out  valid/ready   integral_sum[27:0], integral_square_sum[35:0], frame_last
// csr_chan  in   valid/ready   index[3:0], data[10:0]; ready always high
//
// one pixel word per cycle sustained while rsp_chan.ready is high; a result is offered
// once its pixel has passed stage one and then the output register
// the line store does one write and one registered read per cycle, with a bypass for
// the column being written, so the line store does not hold the rate below one word per cycle
// a stalled result holds the output register; stage one takes one more word, then
// req_chan.ready drops until the result is taken
// reset clears counters, row sums and the line store fill count; no clearing pass
// is needed, columns past the fill count read as zero
module integral_and_squared_integral_image_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   iisq_req_if.sink    req_chan,
   iisq_rsp_if.source  rsp_chan,
   iisq_csr_if.sink    csr_chan
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                    in_ready;
   logic                    accept;
   logic [COL_W-1:0]        col;
   iisq_pkg::pos_flags_type flags;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;

   // a pixel word is taken whenever stage one is free or moving on
   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   // frame position, size registers and end of row / frame flags
   iisq_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .accept    (accept),
      .col       (col),
      .flags     (flags)
   );

   // row sums, line store, integral adds and output register
   iisq_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_chan.pixel),
      .col       (col),
      .flags     (flags),
      .in_ready  (in_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_sum   (rsp_chan.integral_sum),
      .rsp_sq    (rsp_chan.integral_square_sum),
      .rsp_last  (rsp_chan.frame_last)
   );

endmodule

/* test/iisq_tb_pkg.sv */
`timescale 1ns / 100ps

package iisq_tb_pkg;
   import iisq_pkg::*;

   localparam int MAX_SIZE = 1024;

   typedef struct {
      logic [SUM_OUT_W-1:0] integral_sum;
      logic [SQ_OUT_W-1:0]  integral_square_sum;
      logic                 frame_last;
   } integral_word_type;

   class integral_image_tracker;
      logic [CFG_W-1:0]  cfg_width;
      logic [CFG_W-1:0]  cfg_height;
      logic [9:0]        next_col;
      logic [9:0]        next_row;
      logic [17:0]       row_sum;
      logic [26:0]       row_sq_sum;
      logic [63:0]       line_sums    [MAX_SIZE];
      logic [63:0]       line_sq_sums [MAX_SIZE];
      integral_word_type due_words [$];
      int                mismatches;

      function new();
         cfg_width  = CFG_SIZE_RESET;
         cfg_height = CFG_SIZE_RESET;
         next_col   = '0;
         next_row   = '0;
         row_sum    = '0;
         row_sq_sum = '0;
         mismatches = 0;
         foreach (line_sums[i]) begin
            line_sums[i]    = '0;
            line_sq_sums[i] = '0;
         end
      endfunction

      // zero acts as one, anything above the store depth as the depth
      function int unsigned active_size(logic [CFG_W-1:0] value);
         if (value == 0) return 1;
         if (value > MAX_SIZE) return MAX_SIZE;
         return value;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] reg_index, logic [CFG_W-1:0] value);
         if (reg_index == REG_FRAME_WIDTH) cfg_width = value;
         else if (reg_index == REG_FRAME_HEIGHT) cfg_height = value;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void take_pixel(logic [PIXEL_W-1:0] pixel);
         logic [63:0]       total;
         logic [63:0]       sq_total;
         logic [63:0]       above;
         logic [63:0]       above_sq;
         int unsigned       col;
         bit                end_row;
         bit                last_row;
         integral_word_type word;
         col        = next_col;
         row_sum    = row_sum + 18'(pixel);
         row_sq_sum = row_sq_sum + 27'(pixel) * 27'(pixel);
         above      = '0;
         above_sq   = '0;
         if (next_row != 0) begin
            above    = line_sums[col];
            above_sq = line_sq_sums[col];
         end
         total    = above + 64'(row_sum);
         sq_total = above_sq + 64'(row_sq_sum);
         line_sums[col]    = total;
         line_sq_sums[col] = sq_total;
         end_row  = (col + 1) >= active_size(cfg_width);
         last_row = (int'(next_row) + 1) >= active_size(cfg_height);
         if (end_row) begin
            next_col   = '0;
            row_sum    = '0;
            row_sq_sum = '0;
            next_row   = last_row ? 10'd0 : next_row + 10'd1;
         end else begin
            next_col = next_col + 10'd1;
         end
         word.integral_sum = (total > SUM_FIELD_MAX) ? SUM_FIELD_MAX[SUM_OUT_W-1:0]
                                                     : total[SUM_OUT_W-1:0];
         word.integral_square_sum = (sq_total > SQ_FIELD_MAX) ? SQ_FIELD_MAX[SQ_OUT_W-1:0]
                                                              : sq_total[SQ_OUT_W-1:0];
         word.frame_last = end_row && last_row;
         due_words.push_back(word);
      endfunction

      function void check_sums(logic [SUM_OUT_W-1:0] got_sum, logic [SQ_OUT_W-1:0] got_sq,
                               logic got_last);
         integral_word_type want;
         if (due_words.size() == 0) begin
            $error("result word with no pixel waiting: integral_sum %0d", got_sum);
            mismatches++;
            return;
         end
         want = due_words.pop_front();
         if (got_sum !== want.integral_sum) begin
            $error("integral_sum expected %0d actual %0d", want.integral_sum, got_sum);
            mismatches++;
         end
         if (got_sq !== want.integral_square_sum) begin
            $error("integral_square_sum expected %0d actual %0d",
                   want.integral_square_sum, got_sq);
            mismatches++;
         end
         if (got_last !== want.frame_last) begin
            $error("frame_last expected %0d actual %0d", want.frame_last, got_last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import iisq_pkg::*;
   import iisq_tb_pkg::*;

   localparam int STALL_PCT     = 11;     // chance of an idle cycle on either side
   localparam int QUIET_LIMIT   = 2000;   // cycles with no handshake before giving up
   localparam int RANDOM_WORDS  = 1930;
   localparam int TAIL_CYCLES   = 8;
   localparam int STEADY_FROM   = 1500;   // window of pixel counts with no idling at all
   localparam int STEADY_TO     = 1750;
   localparam int WIDE_AFTER    = 300;    // when the full-width pass starts
   localparam int WIDE_WORDS    = 1100;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_REG = REG_FRAME_HEIGHT + 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   bit   wide_done = 1'b0;
   int   sent = 0;
   int   quiet_cycles = 0;

   integral_image_tracker tracker = new();

   iisq_req_if pixel_bus ();
   iisq_rsp_if sum_bus ();
   iisq_csr_if cfg_bus ();

   integral_and_squared_integral_image_unit #(
      .MAX_WIDTH  (MAX_SIZE),
      .MAX_HEIGHT (MAX_SIZE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_bus),
      .rsp_chan (sum_bus),
      .csr_chan (cfg_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure, changed only at the falling edge
   always @(negedge clock) begin
      sum_bus.ready <= steady || ($urandom_range(99) >= STALL_PCT);
   end

   // everything is observed at the rising edge: predict on pixel words,
   // compare on result words, track register writes, and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (pixel_bus.valid && pixel_bus.ready) begin
            tracker.take_pixel(pixel_bus.pixel);
         end
         if (sum_bus.valid && sum_bus.ready) begin
            tracker.check_sums(sum_bus.integral_sum, sum_bus.integral_square_sum,
                               sum_bus.frame_last);
         end
         if (cfg_bus.valid && cfg_bus.ready) begin
            tracker.set_register(cfg_bus.index, cfg_bus.data);
         end
         if ((pixel_bus.valid && pixel_bus.ready) || (sum_bus.valid && sum_bus.ready) ||
             (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // one pixel word; called at a falling edge, returns at the falling edge after acceptance
   task automatic push_pixel(input logic [PIXEL_W-1:0] value);
      steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         pixel_bus.valid = 1'b0;
         @(negedge clock);
      end
      pixel_bus.valid = 1'b1;
      pixel_bus.pixel = value;
      @(posedge clock);
      while (!pixel_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // valid is left high; the caller lowers it after the last write of a group
   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CFG_W-1:0] value);
      cfg_bus.valid = 1'b1;
      cfg_bus.index = reg_index;
      cfg_bus.data  = value;
      @(posedge clock);
      while (!cfg_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // every pixel gives a result, so an empty queue means the block is idle
   task automatic drain();
      pixel_bus.valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] any_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return PIXEL_W'(PIXEL_MAX);
         default: return PIXEL_W'($urandom_range(PIXEL_MAX));
      endcase
   endfunction

   task automatic random_phase();
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;
      int unsigned      area;
      int               words;
      drain();
      if (!wide_done && sent >= WIDE_AFTER) begin
         // full line store width, clamped from all ones
         write_csr(REG_FRAME_WIDTH, '1);
         write_csr(REG_FRAME_HEIGHT, 11'd2);
         cfg_bus.valid = 1'b0;
         wide_done = 1'b1;
         words = WIDE_WORDS;
      end else begin
         case ($urandom_range(9))
            0:       w_val = '0;
            1:       w_val = '1;
            2:       w_val = CFG_W'($urandom_range(25, 80));
            default: w_val = CFG_W'($urandom_range(1, 24));
         endcase
         case ($urandom_range(9))
            0:       h_val = '0;
            1:       h_val = '1;
            default: h_val = CFG_W'($urandom_range(1, 6));
         endcase
         // a lone register write leaves the other size as it stood, often mid-frame
         case ($urandom_range(5))
            0: write_csr(REG_FRAME_WIDTH, w_val);
            1: write_csr(REG_FRAME_HEIGHT, h_val);
            2: begin
               write_csr(REG_FRAME_HEIGHT, h_val);
               write_csr(REG_FRAME_WIDTH, w_val);
            end
            3: begin
               write_csr(CSR_IDX_W'($urandom_range(FIRST_SPARE_REG, (1 << CSR_IDX_W) - 1)),
                         CFG_W'($urandom));
               write_csr(REG_FRAME_WIDTH, w_val);
               write_csr(REG_FRAME_HEIGHT, h_val);
            end
            default: begin
               write_csr(REG_FRAME_WIDTH, w_val);
               write_csr(REG_FRAME_HEIGHT, h_val);
            end
         endcase
         cfg_bus.valid = 1'b0;
         area = tracker.active_size(tracker.cfg_width) * tracker.active_size(tracker.cfg_height);
         if (area <= 60 && $urandom_range(3) != 0) words = area * $urandom_range(1, 3);
         else words = $urandom_range(1, 60);
      end
      repeat (words) push_pixel(any_pixel());
   endtask

   initial begin
      pixel_bus.valid = 1'b0;
      pixel_bus.pixel = '0;
      sum_bus.ready   = 1'b0;
      cfg_bus.valid   = 1'b0;
      cfg_bus.index   = '0;
      cfg_bus.data    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset size, first row: no line store reads yet
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd128);
      push_pixel(8'd1);

      // shrink mid-row: column already past the new width ends the row at once
      drain();
      write_csr(REG_FRAME_WIDTH, 11'd3);
      write_csr(REG_FRAME_HEIGHT, 11'd2);
      cfg_bus.valid = 1'b0;
      repeat (4) push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);

      // zero sizes act as one: every word closes a frame
      drain();
      write_csr(REG_FRAME_WIDTH, '0);
      write_csr(REG_FRAME_HEIGHT, '0);
      cfg_bus.valid = 1'b0;
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd170);

      // writes to registers past the list are dropped; oversized height clamps
      drain();
      write_csr('1, '1);
      write_csr(FIRST_SPARE_REG, '0);
      write_csr(REG_FRAME_WIDTH, 11'd2);
      write_csr(REG_FRAME_HEIGHT, '1);
      cfg_bus.valid = 1'b0;
      repeat (4) push_pixel(8'd255);

      // row counter now past the new last row: this row closes the frame
      drain();
      write_csr(REG_FRAME_HEIGHT, 11'd2);
      cfg_bus.valid = 1'b0;
      push_pixel(8'd255);
      push_pixel(8'd255);

      while (sent < 20 + RANDOM_WORDS) random_phase();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
